>>> hw/rtl/skvt_pkg.sv
package skvt_pkg;

   localparam int CAPACITY    = 16;
   localparam int KEY_WIDTH   = 32;
   localparam int VALUE_WIDTH = 32;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [2:0] MODE_PUT        = 3'd0;
   localparam logic [2:0] MODE_REMOVE     = 3'd1;
   localparam logic [2:0] MODE_LOOKUP     = 3'd2;
   localparam logic [2:0] MODE_WALK_FIRST = 3'd3;
   localparam logic [2:0] MODE_WALK_NEXT  = 3'd4;
   localparam logic [2:0] MODE_CLEAR      = 3'd5;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_ABSENT = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;
   localparam logic [1:0] STATUS_END    = 2'd3;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] key;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] value_out;
      logic [31:0] key_out;
      logic [4:0]  entry_count;
   } rsp_type;

endpackage

>>> hw/rtl/sorted_key_value_table_unit.sv
// Latency: clear, unused modes and a walk that has ended answer one cycle after acceptance;
// a walk step answers after two. Lookup and remove scan the held entries, one per cycle
// through the key memory read port: up to count+1 cycles, remove adds one per entry moved.
// Put scans all entries, then moves each later entry up one per cycle: up to 2*count+2.
// Results cannot be stalled; one word at a time, the next accepted as the result shows.
// Synchronous reset empties the table, rewinds the walk and selects unsigned key order.
module sorted_key_value_table_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  skvt_pkg::req_type req,
   input  logic              csr_write_enable,
   input  logic              csr_write_data,
   output logic              rsp_strobe,
   output skvt_pkg::rsp_type rsp
);
   import skvt_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SCAN     = 3'd1;
   localparam logic [2:0] ST_SHIFT_UP = 3'd2;
   localparam logic [2:0] ST_PUT_WR   = 3'd3;
   localparam logic [2:0] ST_SHIFT_DN = 3'd4;
   localparam logic [2:0] ST_WALK     = 3'd5;

   logic [KEY_WIDTH-1:0]   key_mem [CAPACITY];
   logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];

   logic [2:0]             state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       cursor_ff, cursor_in;
   logic                   order_signed_ff;
   logic [IDX_W-1:0]       cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [IDX_W-1:0]       ins_idx_ff, ins_idx_in;
   logic                   ins_found_ff, ins_found_in;
   logic [2:0]             mode_ff;
   logic [KEY_WIDTH-1:0]   key_ff;
   logic [VALUE_WIDTH-1:0] value_ff;
   logic [KEY_WIDTH-1:0]   rd_key_ff;
   logic [VALUE_WIDTH-1:0] rd_val_ff;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_key_en;
   logic                   wr_val_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [KEY_WIDTH-1:0]   wr_key;
   logic [VALUE_WIDTH-1:0] wr_val;

   logic                   accept;
   logic                   match_now;
   logic                   lt_now;
   logic                   last_now;
   logic [CNT_W-1:0]       cmp_next;
   logic [CNT_W-1:0]       ins_cnt;
   logic [KEY_WIDTH-1:0]   sign_flip;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign sign_flip = {order_signed_ff, {(KEY_WIDTH-1){1'b0}}};
   assign cmp_next  = CNT_W'(cmp_idx_ff) + CNT_W'(1);
   assign match_now = (rd_key_ff == key_ff);
   assign lt_now    = ((key_ff ^ sign_flip) < (rd_key_ff ^ sign_flip));
   assign last_now  = (cmp_next == count_ff);
   assign ins_cnt   = ins_found_ff ? CNT_W'(ins_idx_ff)
                    : (lt_now ? CNT_W'(cmp_idx_ff) : count_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      cmp_idx_in    = cmp_idx_ff;
      idx_in        = idx_ff;
      ins_idx_in    = ins_idx_ff;
      ins_found_in  = ins_found_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;
      wr_key_en     = 1'b0;
      wr_val_en     = 1'b0;
      wr_addr       = idx_ff;
      wr_key        = key_ff;
      wr_val        = value_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ins_found_in = 1'b0;
               cmp_idx_in   = '0;
               case (req.mode)
                  MODE_PUT, MODE_REMOVE, MODE_LOOKUP: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        if (req.mode == MODE_PUT) begin
                           wr_key_en = 1'b1;
                           wr_val_en = 1'b1;
                           wr_addr   = '0;
                           wr_key    = req.key[KEY_WIDTH-1:0];
                           wr_val    = req.value[VALUE_WIDTH-1:0];
                           count_in  = CNT_W'(1);
                        end else begin
                           rsp_in.status = STATUS_ABSENT;
                        end
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  MODE_WALK_FIRST: begin
                     cursor_in = '0;
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = STATUS_END;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = ST_WALK;
                     end
                  end
                  MODE_WALK_NEXT: begin
                     if (cursor_ff >= count_ff) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = STATUS_END;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = cursor_ff[IDX_W-1:0];
                        state_in = ST_WALK;
                     end
                  end
                  MODE_CLEAR: begin
                     count_in      = '0;
                     cursor_in     = '0;
                     rsp_strobe_in = 1'b1;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (lt_now && !ins_found_ff) begin
               ins_found_in = 1'b1;
               ins_idx_in   = cmp_idx_ff;
            end
            if (match_now) begin
               case (mode_ff)
                  MODE_PUT: begin
                     wr_val_en     = 1'b1;
                     wr_addr       = cmp_idx_ff;
                     rsp_strobe_in = 1'b1;
                     state_in      = ST_IDLE;
                  end
                  MODE_REMOVE: begin
                     if (last_now) begin
                        count_in      = count_ff - CNT_W'(1);
                        rsp_strobe_in = 1'b1;
                        state_in      = ST_IDLE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = cmp_next[IDX_W-1:0];
                        idx_in   = cmp_next[IDX_W-1:0];
                        state_in = ST_SHIFT_DN;
                     end
                  end
                  default: begin
                     rsp_in.value_out[VALUE_WIDTH-1:0] = rd_val_ff;
                     rsp_strobe_in = 1'b1;
                     state_in      = ST_IDLE;
                  end
               endcase
            end else if (last_now) begin
               if (mode_ff != MODE_PUT) begin
                  rsp_in.status = STATUS_ABSENT;
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end else if (count_ff == CNT_W'(CAPACITY)) begin
                  rsp_in.status = STATUS_FULL;
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end else if (ins_cnt == count_ff) begin
                  wr_key_en     = 1'b1;
                  wr_val_en     = 1'b1;
                  wr_addr       = count_ff[IDX_W-1:0];
                  count_in      = count_ff + CNT_W'(1);
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  ins_idx_in = ins_cnt[IDX_W-1:0];
                  rd_en      = 1'b1;
                  rd_addr    = cmp_idx_ff;
                  idx_in     = cmp_idx_ff;
                  state_in   = ST_SHIFT_UP;
               end
            end else begin
               rd_en      = 1'b1;
               rd_addr    = cmp_next[IDX_W-1:0];
               cmp_idx_in = cmp_next[IDX_W-1:0];
            end
         end
         ST_SHIFT_UP: begin
            wr_key_en = 1'b1;
            wr_val_en = 1'b1;
            wr_addr   = idx_ff + IDX_W'(1);
            wr_key    = rd_key_ff;
            wr_val    = rd_val_ff;
            if (idx_ff == ins_idx_ff) begin
               state_in = ST_PUT_WR;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff - IDX_W'(1);
               idx_in   = idx_ff - IDX_W'(1);
            end
         end
         ST_PUT_WR: begin
            wr_key_en     = 1'b1;
            wr_val_en     = 1'b1;
            wr_addr       = ins_idx_ff;
            count_in      = count_ff + CNT_W'(1);
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SHIFT_DN: begin
            wr_key_en = 1'b1;
            wr_val_en = 1'b1;
            wr_addr   = idx_ff - IDX_W'(1);
            wr_key    = rd_key_ff;
            wr_val    = rd_val_ff;
            if ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff) begin
               count_in      = count_ff - CNT_W'(1);
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff + IDX_W'(1);
               idx_in   = idx_ff + IDX_W'(1);
            end
         end
         ST_WALK: begin
            rsp_in.key_out[KEY_WIDTH-1:0] = rd_key_ff;
            cursor_in     = cursor_ff + CNT_W'(1);
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in.entry_count = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (wr_key_en) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (rd_en) begin
         rd_key_ff <= key_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_val_en) begin
         val_mem[wr_addr] <= wr_val;
      end
      if (rd_en) begin
         rd_val_ff <= val_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         count_ff        <= '0;
         cursor_ff       <= '0;
         order_signed_ff <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         cursor_ff     <= cursor_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write_enable) begin
            order_signed_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff   <= cmp_idx_in;
      idx_ff       <= idx_in;
      ins_idx_ff   <= ins_idx_in;
      ins_found_ff <= ins_found_in;
      rsp_ff       <= rsp_in;
      if (accept) begin
         mode_ff  <= req.mode;
         key_ff   <= req.key[KEY_WIDTH-1:0];
         value_ff <= req.value[VALUE_WIDTH-1:0];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while still working");

   a_clear_answer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req.mode == MODE_CLEAR) |=>
         (rsp_strobe && rsp.entry_count == 5'd0 && rsp.status == STATUS_OK))
      else $error("clear did not empty the table");

   a_shift_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT_UP || state_ff == ST_SHIFT_DN) |-> !rsp_strobe_in || !wr_key_en
         || state_ff == ST_SHIFT_DN)
      else $error("insert answered before the new entry was written");

endmodule

>>> sim/sorted_key_value_table_unit_check.sv
module sorted_key_value_table_unit_check (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  skvt_pkg::req_type req,
   input  logic              csr_write_enable,
   input  logic              csr_write_data,
   input  logic              rsp_strobe,
   input  skvt_pkg::rsp_type rsp,
   output int                mismatches,
   output int                outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   import skvt_pkg::*;

   logic [31:0] held_keys [CAPACITY];
   logic [31:0] held_values [CAPACITY];
   int          held_count;
   int          walk_pos;
   logic        signed_order;
   rsp_type     pending_answers [$];

   initial begin
      mismatches = 0;
      outstanding = 0;
      held_count = 0;
      walk_pos = 0;
      signed_order = 1'b0;
   end

   function automatic int slot_of(logic [31:0] k);
      for (int i = 0; i < held_count; i++) begin
         if (held_keys[i] == k) return i;
      end
      return held_count;
   endfunction

   function automatic bit orders_before(logic [31:0] a, logic [31:0] b);
      if (signed_order) return $signed(a) < $signed(b);
      return a < b;
   endfunction

   function automatic void walk_step(inout rsp_type ans);
      if (walk_pos >= held_count) begin
         ans.status = STATUS_END;
      end else begin
         ans.key_out = held_keys[walk_pos];
         walk_pos++;
      end
   endfunction

   function automatic rsp_type table_answer(req_type w);
      rsp_type ans;
      int      s;
      ans = '0;
      ans.status = STATUS_OK;
      case (w.mode)
         MODE_PUT: begin
            s = slot_of(w.key);
            if (s < held_count) begin
               held_values[s] = w.value;
            end else if (held_count >= CAPACITY) begin
               ans.status = STATUS_FULL;
            end else begin
               s = 0;
               while (s < held_count && !orders_before(w.key, held_keys[s])) s++;
               for (int i = held_count; i > s; i--) begin
                  held_keys[i] = held_keys[i-1];
                  held_values[i] = held_values[i-1];
               end
               held_keys[s] = w.key;
               held_values[s] = w.value;
               held_count++;
            end
         end
         MODE_REMOVE: begin
            s = slot_of(w.key);
            if (s >= held_count) begin
               ans.status = STATUS_ABSENT;
            end else begin
               for (int i = s; i + 1 < held_count; i++) begin
                  held_keys[i] = held_keys[i+1];
                  held_values[i] = held_values[i+1];
               end
               held_count--;
            end
         end
         MODE_LOOKUP: begin
            s = slot_of(w.key);
            if (s >= held_count) ans.status = STATUS_ABSENT;
            else ans.value_out = held_values[s];
         end
         MODE_WALK_FIRST: begin
            walk_pos = 0;
            walk_step(ans);
         end
         MODE_WALK_NEXT: begin
            walk_step(ans);
         end
         MODE_CLEAR: begin
            held_count = 0;
            walk_pos = 0;
         end
         default: begin
         end
      endcase
      ans.entry_count = held_count[4:0];
      return ans;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         pending_answers.delete();
         held_count = 0;
         walk_pos = 0;
         signed_order = 1'b0;
      end else begin
         if (rsp_strobe) begin
            if (pending_answers.size() == 0) begin
               $error("result word with no word pending");
               mismatches++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp.status);
                  mismatches++;
               end
               if (rsp.value_out !== want.value_out) begin
                  $error("value_out: expected %h, actual %h", want.value_out, rsp.value_out);
                  mismatches++;
               end
               if (rsp.key_out !== want.key_out) begin
                  $error("key_out: expected %h, actual %h", want.key_out, rsp.key_out);
                  mismatches++;
               end
               if (rsp.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, actual %0d", want.entry_count,
                     rsp.entry_count);
                  mismatches++;
               end
            end
         end
         if (csr_write_enable) signed_order = csr_write_data;
         if (start && !busy) pending_answers.push_back(table_answer(req));
      end
      outstanding = pending_answers.size();
   end

endmodule

>>> sim/sorted_key_value_table_unit_test.sv
module sorted_key_value_table_unit_test;

   timeunit 1ns;
   timeprecision 1ps;

   import skvt_pkg::*;

   localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
   localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
   localparam int         CYCLE_LIMIT    = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req = '0;
   logic    csr_write_enable = 1'b0;
   logic    csr_write_data = 1'b0;
   logic    rsp_strobe;
   rsp_type rsp;
   int      mismatches;
   int      outstanding;

   logic [31:0] key_pool [24];
   int          idle_pct = 14;
   int          words_sent = 0;
   int          cycle_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sorted_key_value_table_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req              (req),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_strobe       (rsp_strobe),
      .rsp              (rsp)
   );

   sorted_key_value_table_unit_check i_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req              (req),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_strobe       (rsp_strobe),
      .rsp              (rsp),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   function automatic logic [31:0] pick_key();
      if ($urandom_range(9) == 0) return $urandom;
      return key_pool[$urandom_range(23)];
   endfunction

   function automatic logic [2:0] pick_mode();
      int r;
      r = $urandom_range(99);
      if (r < 38) return MODE_PUT;
      if (r < 52) return MODE_REMOVE;
      if (r < 70) return MODE_LOOKUP;
      if (r < 75) return MODE_WALK_FIRST;
      if (r < 90) return MODE_WALK_NEXT;
      if (r < 93) return MODE_CLEAR;
      if (r < 96) return MODE_UNUSED_LO;
      return MODE_UNUSED_HI;
   endfunction

   task automatic send_word(logic [2:0] mode, logic [31:0] key, logic [31:0] value);
      req_type w;
      w.mode = mode;
      w.key = key;
      w.value = value;
      while ($urandom_range(99) < idle_pct) @(negedge clock) start <= 1'b0;
      @(negedge clock);
      start <= 1'b1;
      req <= w;
      do @(posedge clock); while (busy);
      words_sent++;
   endtask

   task automatic drain();
      @(negedge clock) start <= 1'b0;
      while (outstanding != 0 || busy) @(negedge clock);
   endtask

   task automatic write_order(logic signed_keys);
      drain();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= signed_keys;
      @(negedge clock) csr_write_enable <= 1'b0;
   endtask

   task automatic walk_sequence(int steps);
      send_word(MODE_WALK_FIRST, $urandom, $urandom);
      repeat (steps) begin
         if ($urandom_range(9) == 0) send_word(MODE_REMOVE, pick_key(), $urandom);
         send_word(MODE_WALK_NEXT, $urandom, $urandom);
      end
   endtask

   task automatic fill_table();
      send_word(MODE_CLEAR, $urandom, $urandom);
      for (int i = 0; i < CAPACITY + 2; i++) send_word(MODE_PUT, key_pool[i], $urandom);
      walk_sequence(CAPACITY + 1);
   endtask

   task automatic run_phase(int words);
      int first;
      first = words_sent;
      fill_table();
      while (words_sent - first < words) begin
         if ($urandom_range(99) < 10) walk_sequence($urandom_range(1, 18));
         else send_word(pick_mode(), pick_key(), $urandom);
      end
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hffff_ffff;
      key_pool[2] = 32'h7fff_ffff;
      key_pool[3] = 32'h8000_0000;
      key_pool[4] = 32'h0000_0001;
      key_pool[5] = 32'h8000_0001;
      key_pool[6] = 32'hffff_fffe;
      key_pool[7] = 32'h7fff_fffe;
      for (int i = 8; i < 24; i++) key_pool[i] = $urandom;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      send_word(MODE_LOOKUP, 32'h0000_0005, 32'h0);
      send_word(MODE_WALK_FIRST, 32'h0, 32'h0);
      send_word(MODE_WALK_NEXT, 32'h0, 32'h0);
      send_word(MODE_REMOVE, 32'h0, 32'h0);
      send_word(MODE_PUT, 32'hffff_ffff, 32'hffff_ffff);
      send_word(MODE_PUT, 32'h0000_0000, 32'h0000_0000);
      send_word(MODE_PUT, 32'h8000_0000, 32'h1234_5678);
      send_word(MODE_PUT, 32'h7fff_ffff, 32'ha5a5_a5a5);
      send_word(MODE_PUT, 32'h0000_0001, 32'h5a5a_5a5a);
      send_word(MODE_PUT, 32'h0000_0000, 32'hffff_ffff);
      send_word(MODE_LOOKUP, 32'h0000_0000, 32'h0);
      send_word(MODE_WALK_FIRST, 32'h0, 32'h0);
      send_word(MODE_WALK_NEXT, 32'h0, 32'h0);
      send_word(MODE_REMOVE, 32'h7fff_ffff, 32'h0);
      send_word(MODE_WALK_NEXT, 32'h0, 32'h0);
      send_word(MODE_WALK_NEXT, 32'h0, 32'h0);
      send_word(MODE_WALK_NEXT, 32'h0, 32'h0);
      send_word(MODE_LOOKUP, 32'h7fff_ffff, 32'h0);
      send_word(MODE_UNUSED_LO, 32'h0, 32'h0);
      send_word(MODE_UNUSED_HI, 32'hffff_ffff, 32'hffff_ffff);
      send_word(MODE_CLEAR, 32'h0, 32'h0);
      send_word(MODE_WALK_NEXT, 32'h0, 32'h0);
      send_word(MODE_LOOKUP, 32'hffff_ffff, 32'h0);

      write_order(1'b1);
      run_phase(130);
      write_order(1'b0);
      idle_pct = 0;
      run_phase(130);
      idle_pct = 14;
      write_order(1'b1);
      run_phase(140);
      drain();
      repeat (40) @(posedge clock);

      if (mismatches == 0 && outstanding == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
